### design/label_value_line_parser_core_macros.svh
// ----------------------------------------------------------------------------
// label_value_line_parser_core_macros.svh
// Assertion helpers for the label and value line parser.
// ----------------------------------------------------------------------------
`ifndef LABEL_VALUE_LINE_PARSER_CORE_MACROS_SVH
`define LABEL_VALUE_LINE_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and off while rst_n is low.
`define LVLP_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and off while rst_n is low.
`define LVLP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lvlp_pkg.sv
// ----------------------------------------------------------------------------
// lvlp_pkg
// Types, request and response layouts and character codes of the parser.
// ----------------------------------------------------------------------------
package lvlp_pkg;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] text_byte;
    logic       end_of_text;
    logic [3:0] entry_index;
    logic [5:0] char_position;
  } in_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] entry_count;
    logic [7:0] read_byte;
    logic       read_valid;
  } out_rsp_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_COMMENT,
    PH_LABEL,
    PH_VLEAD,
    PH_VALUE
  } phase_t;

  localparam logic [1:0] OP_CLEAR      = 2'd0;
  localparam logic [1:0] OP_TEXT       = 2'd1;
  localparam logic [1:0] OP_READ_LABEL = 2'd2;
  localparam logic [1:0] OP_READ_VALUE = 2'd3;

  localparam logic [2:0] ST_MID     = 3'd0;
  localparam logic [2:0] ST_STORED  = 3'd1;
  localparam logic [2:0] ST_BLANK   = 3'd2;
  localparam logic [2:0] ST_NO_SEP  = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_READ    = 3'd5;

  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

### design/label_value_line_parser_core.sv
// ----------------------------------------------------------------------------
// label_value_line_parser_core
// Parses a byte stream of "label | value" lines into an entry table.
// ----------------------------------------------------------------------------
// The core accepts one request per clock unless its response is stalled, and
// returns exactly one response per request, registered in the cycle after its
// acceptance; a new request is taken in the same cycle the previous response
// is taken, so the sustained rate is one request per cycle while out_stall is
// low. Text bytes update a small line-state machine and write label or value
// bytes straight into the byte stores. Read requests look up the byte store
// and the per-entry length store, both synchronous memories with registered
// read data, and the response is formed from their registered outputs. No
// clearing pass follows reset: only data a stored line wrote is used.
`include "label_value_line_parser_core_macros.svh"

module label_value_line_parser_core #(
  parameter int MAX_ENTRIES = 16,
  parameter int LABEL_BYTES = 32,
  parameter int VALUE_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lvlp_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output lvlp_pkg::out_rsp_t out_rsp
);
  import lvlp_pkg::*;

  localparam int LW     = $clog2(LABEL_BYTES);
  localparam int VW     = $clog2(VALUE_BYTES);
  localparam int PW     = (LW > VW) ? LW : VW;
  localparam int CW     = $clog2(MAX_ENTRIES + 1);
  localparam int EW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LDEPTH = MAX_ENTRIES * LABEL_BYTES;
  localparam int VDEPTH = MAX_ENTRIES * VALUE_BYTES;
  localparam int LAW    = $clog2(LDEPTH);
  localparam int VAW    = $clog2(VDEPTH);

  localparam logic [PW:0]   LCAP    = (PW + 1)'(LABEL_BYTES - 1);
  localparam logic [PW:0]   VCAP    = (PW + 1)'(VALUE_BYTES - 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  // Line state and table count.
  phase_t        phase_r, phase_nxt;
  logic [PW-1:0] pend_r, pend_nxt;
  logic [LW-1:0] cur_lab_r, cur_lab_nxt;
  logic [VW-1:0] cur_val_r, cur_val_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Response stage.
  logic       out_valid_r;
  logic [2:0] rsp_status_r;
  logic       rsp_rv_r;
  logic       rsp_label_r;
  logic [5:0] rsp_pos_r;

  logic       fire;
  logic       ws;
  logic       put_val;
  logic       put_en;
  logic [PW:0] cap;
  logic [PW:0] wpos;
  logic [PW:0] wpos_inc;
  logic [PW:0] new_cur;
  logic       put_write;
  logic [2:0] status_nxt;
  logic       len_we;
  logic [LW-1:0] line_lab_len;
  logic [VW-1:0] line_val_len;
  logic       rd_ok;
  logic       lab_re;
  logic       val_re;
  logic [8:0] idx_ext;

  logic [LAW-1:0] lab_waddr, lab_raddr;
  logic [VAW-1:0] val_waddr, val_raddr;

  logic [7:0]       lab_mem [LDEPTH];
  logic [7:0]       val_mem [VDEPTH];
  logic [LW+VW-1:0] len_mem [MAX_ENTRIES];
  logic [7:0]       lab_rdata_r;
  logic [7:0]       val_rdata_r;
  logic [LW+VW-1:0] len_rdata_r;

  assign fire     = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign ws       = is_ws(in_req.text_byte);

  // The value field is the one being built once the separator has been seen.
  assign put_val  = (phase_r == PH_VLEAD) || (phase_r == PH_VALUE);
  assign cap      = put_val ? VCAP : LCAP;
  assign wpos     = (put_val ? (PW + 1)'(cur_val_r) : (PW + 1)'(cur_lab_r))
                    + (PW + 1)'(pend_r);
  assign wpos_inc = wpos + 1'b1;
  assign new_cur  = (wpos_inc < cap) ? wpos_inc : cap;
  assign put_write = put_en && (wpos < cap) && (cnt_r < MAX_CNT);

  assign lab_waddr = LAW'(int'(cnt_r) * LABEL_BYTES + int'(wpos));
  assign val_waddr = VAW'(int'(cnt_r) * VALUE_BYTES + int'(wpos));
  assign lab_raddr = LAW'(int'(in_req.entry_index) * LABEL_BYTES
                          + int'(in_req.char_position));
  assign val_raddr = VAW'(int'(in_req.entry_index) * VALUE_BYTES
                          + int'(in_req.char_position));

  assign idx_ext = 9'(in_req.entry_index);
  assign rd_ok   = (idx_ext < 9'(cnt_r)) && (idx_ext < 9'(MAX_ENTRIES));
  assign lab_re  = fire && (in_req.opcode == OP_READ_LABEL) && rd_ok;
  assign val_re  = fire && (in_req.opcode == OP_READ_VALUE) && rd_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      pend_r      <= '0;
      cur_lab_r   <= '0;
      cur_val_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pend_r      <= pend_nxt;
      cur_lab_r   <= cur_lab_nxt;
      cur_val_r   <= cur_val_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= fire || (out_valid_r && out_stall);
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    pend_nxt     = pend_r;
    cur_lab_nxt  = cur_lab_r;
    cur_val_nxt  = cur_val_r;
    cnt_nxt      = cnt_r;
    put_en       = 1'b0;
    status_nxt   = ST_MID;
    len_we       = 1'b0;
    line_lab_len = '0;
    line_val_len = '0;
    if (fire) begin
      case (in_req.opcode)
        OP_CLEAR: begin
          cnt_nxt     = '0;
          phase_nxt   = PH_START;
          pend_nxt    = '0;
          cur_lab_nxt = '0;
          cur_val_nxt = '0;
        end
        OP_TEXT: begin
          if (in_req.text_byte != CH_LF) begin
            case (phase_r)
              PH_START: begin
                if (!ws) begin
                  if (in_req.text_byte == CH_HASH) begin
                    phase_nxt = PH_COMMENT;
                  end else if (in_req.text_byte == CH_PIPE) begin
                    phase_nxt = PH_VLEAD;
                  end else begin
                    phase_nxt = PH_LABEL;
                    put_en    = 1'b1;
                  end
                end
              end
              PH_LABEL: begin
                if (in_req.text_byte == CH_PIPE) begin
                  // Whitespace held before the separator is trailing label space.
                  pend_nxt  = '0;
                  phase_nxt = PH_VLEAD;
                end else begin
                  put_en = 1'b1;
                end
              end
              PH_VLEAD: begin
                if (!ws) begin
                  phase_nxt = PH_VALUE;
                  put_en    = 1'b1;
                end
              end
              PH_VALUE: begin
                put_en = 1'b1;
              end
              default: begin
              end
            endcase
          end
          // Whitespace is written but only counted once a later byte follows.
          if (put_en) begin
            if (ws) begin
              if ((PW + 1)'(pend_r) < cap) begin
                pend_nxt = pend_r + 1'b1;
              end
            end else begin
              pend_nxt = '0;
              if (put_val) begin
                cur_val_nxt = new_cur[VW-1:0];
              end else begin
                cur_lab_nxt = new_cur[LW-1:0];
              end
            end
          end
          if ((in_req.text_byte == CH_LF) || in_req.end_of_text) begin
            // The lengths of the closing line are taken before the line state clears.
            line_lab_len = cur_lab_nxt;
            line_val_len = cur_val_nxt;
            if ((phase_nxt == PH_START) || (phase_nxt == PH_COMMENT)) begin
              status_nxt = ST_BLANK;
            end else if (phase_nxt == PH_LABEL) begin
              status_nxt = ST_NO_SEP;
            end else if (cnt_r >= MAX_CNT) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt = ST_STORED;
              len_we     = 1'b1;
              cnt_nxt    = cnt_r + 1'b1;
            end
            phase_nxt   = PH_START;
            pend_nxt    = '0;
            cur_lab_nxt = '0;
            cur_val_nxt = '0;
          end
        end
        default: begin
          status_nxt = ST_READ;
        end
      endcase
    end
  end

  // Byte and length stores; writes and reads always belong to different requests.
  always_ff @(posedge clk) begin
    if (put_write && !put_val) begin
      lab_mem[lab_waddr] <= in_req.text_byte;
    end
    if (lab_re) begin
      lab_rdata_r <= lab_mem[lab_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (put_write && put_val) begin
      val_mem[val_waddr] <= in_req.text_byte;
    end
    if (val_re) begin
      val_rdata_r <= val_mem[val_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[EW'(cnt_r)] <= {line_lab_len, line_val_len};
    end
    if (lab_re || val_re) begin
      len_rdata_r <= len_mem[EW'(in_req.entry_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_status_r <= status_nxt;
      rsp_rv_r     <= in_req.opcode[1] && rd_ok;
      rsp_label_r  <= (in_req.opcode == OP_READ_LABEL);
      rsp_pos_r    <= in_req.char_position;
    end
  end

  logic [LW-1:0] rd_llen;
  logic [VW-1:0] rd_vlen;
  logic [7:0]    rd_byte;

  assign rd_llen = len_rdata_r[LW+VW-1:VW];
  assign rd_vlen = len_rdata_r[VW-1:0];

  always_comb begin
    rd_byte = 8'd0;
    if (rsp_rv_r) begin
      if (rsp_label_r) begin
        if (9'(rsp_pos_r) < 9'(rd_llen)) begin
          rd_byte = lab_rdata_r;
        end
      end else begin
        if (9'(rsp_pos_r) < 9'(rd_vlen)) begin
          rd_byte = val_rdata_r;
        end
      end
    end
  end

  // The count register only moves on acceptance, so it matches the held response.
  assign out_valid           = out_valid_r;
  assign out_rsp.status      = rsp_status_r;
  assign out_rsp.entry_count = 5'(cnt_r);
  assign out_rsp.read_byte   = rd_byte;
  assign out_rsp.read_valid  = rsp_rv_r;

  `LVLP_ASSERT_IMPLY(a_rv_only_on_read, out_valid_r && rsp_rv_r, rsp_status_r == ST_READ, "read_valid on a non-read response")
  `LVLP_ASSERT_IMPLY(a_count_bounded, 1'b1, cnt_r <= MAX_CNT, "entry count above table size")
  `LVLP_ASSERT_NEXT(a_clear_empties, fire && (in_req.opcode == OP_CLEAR), out_valid_r && (cnt_r == '0) && (phase_r == PH_START), "clear request left entries or a line")
  `LVLP_ASSERT_NEXT(a_store_counts, fire && (status_nxt == ST_STORED), cnt_r == $past(cnt_r) + 1'b1, "stored line did not advance the count")

endmodule
